FILE: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared definitions for the dual stack shared buffer
// Field widths, input kind codes, decoded operation codes and status codes.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DSS_DEPTH   = 64;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 7;
    localparam int LEN_W       = 7;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int Q_DEPTH     = 2;

    // Raw kind codes as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RUN       = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK,
        OP_CLEAR,
        OP_CLEAR_ALL,
        OP_RUN,
        OP_NOP
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        op_t              op;
        logic             side;
        logic [DATA_W-1:0] char_in;
        logic [LEN_W-1:0] read_len;
        logic             reverse_order;
    } cmd_t;

endpackage

FILE: src/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram: generic single write port, single read port RAM
// The read data is registered and only updates when a read is enabled.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front: input acceptance and classification
// Decodes each input beat into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module dss_front import dss_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // char_in[7:0], read_len[14:8], reverse_order[15]
    input  logic [3:0]         s_tuser,   // kind[2:0], side[3]
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int QC_W  = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;
    cmd_t             dec_cmd;
    logic             push;

    always_comb begin
        dec_cmd.side          = s_tuser[3];
        dec_cmd.char_in       = s_tdata[7:0];
        dec_cmd.read_len      = s_tdata[14:8];
        dec_cmd.reverse_order = s_tdata[15];
        unique case (s_tuser[2:0])
            KIND_PUSH:      dec_cmd.op = OP_PUSH;
            KIND_POP:       dec_cmd.op = OP_POP;
            KIND_PEEK:      dec_cmd.op = OP_PEEK;
            KIND_CLEAR:     dec_cmd.op = OP_CLEAR;
            KIND_CLEAR_ALL: dec_cmd.op = OP_CLEAR_ALL;
            KIND_RUN:       dec_cmd.op = OP_RUN;
            default:        dec_cmd.op = OP_NOP;
        endcase
    end

    assign s_tready = (count_reg != QC_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

FILE: src/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back: command execution
// Holds both stack counts and the byte store, runs commands and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module dss_back import dss_pkg::*; #(
    parameter int DEPTH = DSS_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_out[7:0], left_count[14:8], right_count[21:15]
    output logic [2:0]  m_tuser,   // char_valid[0], status[2:1]
    output logic        m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_STREAM = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     right_reg, right_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              up_reg, up_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_char_reg;
    logic              out_cv_reg;
    status_t           out_status_reg;
    logic [CW-1:0]     out_left_reg, out_right_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              emit;
    logic [DATA_W-1:0] e_char;
    logic              e_cv;
    status_t           e_status;
    logic              e_last;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [CW-1:0]     cnt_sel;
    logic [LEN_W-1:0]  cnt_ext, run_n;
    logic [AW-1:0]     run_nm1, top_left, top_right, top_sel, run_start;
    logic              is_full;

    dss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_cmd.char_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign cnt_sel   = q_cmd.side ? right_reg : left_reg;
    assign cnt_ext   = LEN_W'(cnt_sel);
    assign run_n     = (q_cmd.read_len < cnt_ext) ? q_cmd.read_len : cnt_ext;
    assign run_nm1   = AW'(run_n - 1'b1);
    assign top_left  = AW'(left_reg - 1'b1);
    assign top_right = AW'(DEPTH_C - right_reg);
    assign top_sel   = q_cmd.side ? top_right : top_left;
    assign is_full   = ({1'b0, left_reg} + {1'b0, right_reg}) >= {1'b0, DEPTH_C};

    // A reversed run starts at the oldest byte of the run and walks toward the top.
    always_comb begin
        if (!q_cmd.reverse_order) begin
            run_start = top_sel;
        end else if (q_cmd.side) begin
            run_start = top_right + run_nm1;
        end else begin
            run_start = top_left - run_nm1;
        end
    end

    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        right_next = right_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        up_next    = up_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_re     = 1'b0;
        ram_raddr  = addr_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        e_char     = '0;
        e_cv       = 1'b0;
        e_status   = STAT_OK;
        e_last     = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (q_cmd.op)
                        OP_PUSH: begin
                            if (is_full) begin
                                e_status = STAT_FULL;
                            end else if (q_cmd.side) begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(DEPTH_C - right_reg - 1'b1);
                                right_next = right_reg + 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(left_reg);
                                left_next = left_reg + 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (cnt_sel == '0) begin
                                e_status = STAT_EMPTY;
                            end else begin
                                emit       = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = top_sel;
                                rem_next   = LEN_W'(1);
                                state_next = ST_STREAM;
                                if (q_cmd.op == OP_POP) begin
                                    if (q_cmd.side) begin
                                        right_next = right_reg - 1'b1;
                                    end else begin
                                        left_next = left_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        OP_CLEAR: begin
                            if (q_cmd.side) begin
                                right_next = '0;
                            end else begin
                                left_next = '0;
                            end
                        end
                        OP_CLEAR_ALL: begin
                            left_next  = '0;
                            right_next = '0;
                        end
                        OP_RUN: begin
                            if (run_n != '0) begin
                                emit       = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = run_start;
                                up_next    = q_cmd.side ^ q_cmd.reverse_order;
                                addr_next  = (q_cmd.side ^ q_cmd.reverse_order) ?
                                             run_start + 1'b1 : run_start - 1'b1;
                                rem_next   = run_n;
                                state_next = ST_STREAM;
                            end
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STREAM: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = ram_rdata;
                    e_cv   = 1'b1;
                    e_last = (rem_reg == LEN_W'(1));
                    if (rem_reg > LEN_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_reg;
                        addr_next = up_reg ? addr_reg + 1'b1 : addr_reg - 1'b1;
                        rem_next  = rem_reg - 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            rem_reg   <= rem_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        up_reg   <= up_next;
        if (emit) begin
            out_char_reg   <= e_char;
            out_cv_reg     <= e_cv;
            out_status_reg <= e_status;
            out_left_reg   <= left_next;
            out_right_reg  <= right_next;
            out_last_reg   <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, CNT_W'(out_right_reg), CNT_W'(out_left_reg), out_char_reg};
    assign m_tuser  = {out_status_reg, out_cv_reg};
    assign m_tlast  = out_last_reg;

    // The two stacks together never claim more than the store holds.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, left_reg} + {1'b0, right_reg}) <= {1'b0, DEPTH_C})
        else $error("stack counts exceed store depth");

    // While streaming there is always at least one byte still owed.
    a_stream_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM) |-> (rem_reg != '0))
        else $error("streaming with no bytes remaining");

    // Store writes only come from a push taken while idle, never with a read.
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE) && !ram_re && q_pop && !is_full)
        else $error("store write outside an accepted push");

    // A byte is delivered only in the cycle after a store read or while held.
    a_byte_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && e_cv) |-> (state_reg == ST_STREAM))
        else $error("byte result outside a stream");

endmodule

FILE: src/dual_stack_shared_buffer_core.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_core: two byte stacks sharing one store
// With the back idle and the result side ready, push, clear, unused kinds, a
// pop or peek of an empty side and a run clipped to nothing go from the queue
// entry to the result register; a pop, a peek and the first byte of a read run
// also pass the registered store read. While the result side is ready, push and
// clear commands are taken one per cycle, and a pop, peek or read run holds the
// back until its last byte is out, one byte per cycle out of the read port.
// Reset: aresetn low at a clock edge empties both stacks, the command queue
// and the result register; the byte store keeps its contents and needs no pass.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_core import dss_pkg::*; #(
    parameter int DEPTH = DSS_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel: one command per beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_in[7:0], read_len[14:8], reverse_order[15]
    input  logic [3:0]  s_tuser,   // kind[2:0], side[3]
    // Result channel: one beat per result, tlast on the final one of a command.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_out[7:0], left_count[14:8], right_count[21:15]
    output logic [2:0]  m_tuser,   // char_valid[0], status[2:1]
    output logic        m_tlast
);

    // The front classifies incoming beats into commands and buffers two of
    // them, so the input side keeps accepting while the back is busy with a
    // read run or waiting on a stalled result.
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // The back owns both stack counts and the store. The left stack fills
    // upward from address zero, the right stack downward from the top, and
    // the store is full when the two meet. Every result carries both counts
    // as they stand after the command.
    dss_back #(.DEPTH(DEPTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
